### src/assert_macros.svh
// assertion macros for the rtl files, used by the engine
// each expects signals named clock and reset in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### src/smbt_pkg.sv
package smbt_pkg;

   // frame geometry
   localparam int FRAME_BITS = 8;
   localparam int BYTE_BITS = 8;
   localparam int BIT_CNT_W = 4;
   localparam int PRESCALE_W = 7;
   localparam int BAUD_W = 3;
   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(FRAME_BITS - 1);

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAUD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLARITY = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE = 2'd2;

   // one input tick
   typedef struct packed {
      logic                 kind;
      logic [BYTE_BITS-1:0] tx_byte;
      logic                 miso_in;
   } req_word_type;

   // one result tick
   typedef struct packed {
      logic                 sck_out;
      logic                 mosi_out;
      logic                 rx_valid;
      logic [BYTE_BITS-1:0] rx_byte;
      logic                 tx_empty;
      logic                 busy_res;
   } rsp_word_type;

   // configuration write
   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

endpackage

### src/smbt_in_reg.sv
module smbt_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  smbt_pkg::req_word_type req_word,
   input  logic                 advance,
   output logic                 word_valid,
   output smbt_pkg::req_word_type word
);

   logic                   valid_ff, valid_in;
   smbt_pkg::req_word_type word_ff, word_in;
   logic                   take;

   // stage frees up when its word moves on
   assign req_stall = valid_ff && !advance;
   assign take = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      word_in = word_ff;
      if (take) begin
         valid_in = 1'b1;
         word_in = req_word;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word = word_ff;

endmodule

### src/smbt_engine.sv
`include "assert_macros.svh"

module smbt_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  smbt_pkg::csr_write_type csr,
   input  logic                    fire,
   input  smbt_pkg::req_word_type  word,
   output smbt_pkg::rsp_word_type  result
);

   localparam int FB = smbt_pkg::FRAME_BITS;

   // configuration
   logic [smbt_pkg::BAUD_W-1:0] baud_ff;
   logic                        polarity_ff;
   logic                        phase_ff;

   // controller state
   logic [FB-1:0]                   tx_shift_ff, tx_shift_in;
   logic [FB-1:0]                   rx_shift_ff, rx_shift_in;
   logic [FB-1:0]                   rx_holding_ff, rx_holding_in;
   logic [smbt_pkg::BYTE_BITS-1:0]  hold_byte_ff, hold_byte_in;
   logic                            hold_full_ff, hold_full_in;
   logic [smbt_pkg::BIT_CNT_W-1:0]  bit_counter_ff, bit_counter_in;
   logic [smbt_pkg::PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic                            sck_level_ff, sck_level_in;
   logic                            frame_active_ff, frame_active_in;

   logic [smbt_pkg::PRESCALE_W-1:0] limit;
   logic                            leading;
   logic                            last;
   logic                            rx_valid;

   // configuration register decode
   always_ff @(posedge clock) begin
      if (reset) begin
         baud_ff <= '0;
         polarity_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (csr.valid) begin
         unique case (csr.index)
            smbt_pkg::CSR_BAUD: baud_ff <= csr.data[smbt_pkg::BAUD_W-1:0];
            smbt_pkg::CSR_POLARITY: polarity_ff <= csr.data[0];
            smbt_pkg::CSR_PHASE: phase_ff <= csr.data[0];
            default: ;
         endcase
      end
   end

   // half period terminal count
   assign limit = (smbt_pkg::PRESCALE_W'(1) << baud_ff) - smbt_pkg::PRESCALE_W'(1);
   assign leading = (sck_level_ff == polarity_ff);

   // one tick: write, frame start, sck edge, frame end
   always_comb begin
      tx_shift_in = tx_shift_ff;
      rx_shift_in = rx_shift_ff;
      rx_holding_in = rx_holding_ff;
      hold_byte_in = hold_byte_ff;
      hold_full_in = hold_full_ff;
      bit_counter_in = bit_counter_ff;
      prescale_in = prescale_ff;
      sck_level_in = sck_level_ff;
      frame_active_in = frame_active_ff;
      last = 1'b0;
      rx_valid = 1'b0;
      if (fire) begin
         // holding register write, dropped when full
         if (word.kind && !hold_full_ff) begin
            hold_byte_in = word.tx_byte;
            hold_full_in = 1'b1;
         end
         if (!frame_active_ff) begin
            sck_level_in = polarity_ff;
            if (hold_full_in) begin
               tx_shift_in = FB'(hold_byte_in);
               hold_full_in = 1'b0;
               frame_active_in = 1'b1;
               bit_counter_in = '0;
               prescale_in = '0;
               rx_shift_in = '0;
            end
         end else if (prescale_ff >= limit) begin
            prescale_in = '0;
            sck_level_in = ~sck_level_ff;
            if (leading) begin
               if (!phase_ff) begin
                  rx_shift_in = {rx_shift_ff[FB-2:0], word.miso_in};
               end else if (bit_counter_ff != '0) begin
                  tx_shift_in = {tx_shift_ff[FB-2:0], 1'b0};
               end
            end else begin
               if (!phase_ff) begin
                  tx_shift_in = {tx_shift_ff[FB-2:0], 1'b0};
               end else begin
                  rx_shift_in = {rx_shift_ff[FB-2:0], word.miso_in};
               end
               last = (bit_counter_ff >= smbt_pkg::BIT_LAST);
               bit_counter_in = bit_counter_ff + smbt_pkg::BIT_CNT_W'(1);
            end
            // frame end
            if (last) begin
               rx_holding_in = rx_shift_in;
               rx_valid = 1'b1;
               frame_active_in = 1'b0;
               bit_counter_in = '0;
               sck_level_in = polarity_ff;
            end
         end else begin
            prescale_in = prescale_ff + smbt_pkg::PRESCALE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_shift_ff <= '0;
         rx_shift_ff <= '0;
         rx_holding_ff <= '0;
         hold_byte_ff <= '0;
         hold_full_ff <= 1'b0;
         bit_counter_ff <= '0;
         prescale_ff <= '0;
         sck_level_ff <= 1'b0;
         frame_active_ff <= 1'b0;
      end else begin
         tx_shift_ff <= tx_shift_in;
         rx_shift_ff <= rx_shift_in;
         rx_holding_ff <= rx_holding_in;
         hold_byte_ff <= hold_byte_in;
         hold_full_ff <= hold_full_in;
         bit_counter_ff <= bit_counter_in;
         prescale_ff <= prescale_in;
         sck_level_ff <= sck_level_in;
         frame_active_ff <= frame_active_in;
      end
   end

   // result word, values after the tick
   assign result.sck_out = sck_level_in;
   assign result.mosi_out = tx_shift_in[FB-1];
   assign result.rx_valid = rx_valid;
   assign result.rx_byte = smbt_pkg::BYTE_BITS'(rx_holding_in);
   assign result.tx_empty = !hold_full_in;
   assign result.busy_res = frame_active_in;

   // a completed byte always ends the frame
   `ASSERT_IMPLY(a_valid_ends_frame, fire && rx_valid, !frame_active_in)
   // pending byte starts a frame as soon as the line is idle
   `ASSERT_NEXT(a_pending_starts, fire && !frame_active_ff && hold_full_ff, frame_active_ff)
   // bit count stays inside the frame
   `ASSERT_IMPLY(a_bit_range, frame_active_ff, bit_counter_ff <= smbt_pkg::BIT_LAST)
   // idle sck rests at the polarity level
   `ASSERT_IMPLY(a_idle_sck, fire && !frame_active_in, sck_level_in == polarity_ff)

endmodule

### src/smbt_out_reg.sv
module smbt_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  smbt_pkg::rsp_word_type word,
   output logic                   can_load,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output smbt_pkg::rsp_word_type rsp_word
);

   logic                   valid_ff, valid_in;
   smbt_pkg::rsp_word_type word_ff, word_in;

   // register may refill while its word is taken
   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      word_in = word_ff;
      if (load) begin
         valid_in = 1'b1;
         word_in = word;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word = word_ff;

endmodule

### src/spi_master_byte_transceiver_core.sv
// path: an accepted tick word sits in the input register, then takes one combinational
// step through the engine into the result register
// throughput: one tick word per cycle while the receiver does not stall, set by the single-step engine
// reset: synchronous, active high; sck idles low, configuration and all controller state clear
// the csr port is always ready
module spi_master_byte_transceiver_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [smbt_pkg::BYTE_BITS-1:0]      req_tx_byte,
   input  logic                                req_miso_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_sck_out,
   output logic                                rsp_mosi_out,
   output logic                                rsp_rx_valid,
   output logic [smbt_pkg::BYTE_BITS-1:0]      rsp_rx_byte,
   output logic                                rsp_tx_empty,
   output logic                                rsp_busy_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smbt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [smbt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   smbt_pkg::req_word_type  req_word;
   smbt_pkg::req_word_type  stage_word;
   smbt_pkg::rsp_word_type  result;
   smbt_pkg::rsp_word_type  rsp_word;
   smbt_pkg::csr_write_type csr;
   logic                    stage_valid;
   logic                    can_load;
   logic                    fire;

   assign req_word.kind = req_kind;
   assign req_word.tx_byte = req_tx_byte;
   assign req_word.miso_in = req_miso_in;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data = csr_wdata;

   // a tick is processed when the result register has room
   assign fire = stage_valid && can_load;

   smbt_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .advance    (fire),
      .word_valid (stage_valid),
      .word       (stage_word)
   );

   smbt_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .fire   (fire),
      .word   (stage_word),
      .result (result)
   );

   smbt_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .word      (result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_sck_out = rsp_word.sck_out;
   assign rsp_mosi_out = rsp_word.mosi_out;
   assign rsp_rx_valid = rsp_word.rx_valid;
   assign rsp_rx_byte = rsp_word.rx_byte;
   assign rsp_tx_empty = rsp_word.tx_empty;
   assign rsp_busy_res = rsp_word.busy_res;

endmodule

### dv/tb_spi_master_byte_transceiver_core.sv
`timescale 1ns / 1ps

module tb_spi_master_byte_transceiver_core;

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 8;
   localparam int PHASE_COUNT = 12;
   localparam int DIR_N = 24;
   localparam logic [smbt_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // one tick word of the stimulus, with an optional hand-written expectation
   typedef struct packed {
      logic                           kind;
      logic [smbt_pkg::BYTE_BITS-1:0] tx_byte;
      logic                           miso;
      logic                           typed;
      smbt_pkg::rsp_word_type         want;
   } tick_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = 1'b0;
   logic [smbt_pkg::BYTE_BITS-1:0] req_tx_byte = '0;
   logic req_miso_in = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_sck_out;
   logic rsp_mosi_out;
   logic rsp_rx_valid;
   logic [smbt_pkg::BYTE_BITS-1:0] rsp_rx_byte;
   logic rsp_tx_empty;
   logic rsp_busy_res;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [smbt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [smbt_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // expectation that rides along with the word being offered
   logic row_typed = 1'b0;
   smbt_pkg::rsp_word_type row_want = '0;

   int gap_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int mismatches = 0;

   smbt_pkg::rsp_word_type pin_words_due [$];

   // shadow of the controller's configuration and state
   logic [smbt_pkg::BAUD_W-1:0] baud_sel = '0;
   logic cpol = 1'b0;
   logic cpha = 1'b0;
   logic [smbt_pkg::FRAME_BITS-1:0] tx_sr = '0;
   logic [smbt_pkg::FRAME_BITS-1:0] rx_sr = '0;
   logic [smbt_pkg::BYTE_BITS-1:0] rx_hold = '0;
   logic [smbt_pkg::BYTE_BITS-1:0] hold_data = '0;
   logic hold_full = 1'b0;
   logic [smbt_pkg::BIT_CNT_W-1:0] bit_cnt = '0;
   logic [smbt_pkg::PRESCALE_W-1:0] pre_cnt = '0;
   logic sck_lvl = 1'b0;
   logic in_frame = 1'b0;

   tick_row_type dir_rows [DIR_N] = '{
      // idle right after reset
      '{1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0}},
      // write while idle starts a frame at once, msb on mosi
      '{1'b1, 8'hA5, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1}},
      // second byte goes to the holding register, third is dropped
      '{1'b1, 8'h3C, 1'b1, 1'b0, '0},
      '{1'b1, 8'hFF, 1'b0, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'hFF, 1'b0, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, 1'b0, '0},
      // last edge of the first frame, then the held byte starts
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, 1'b0, '0},
      '{1'b1, 8'h00, 1'b1, 1'b0, '0},
      '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
      '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
      '{1'b0, 8'hFF, 1'b1, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, 1'b0, '0}
   };

   spi_master_byte_transceiver_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_tx_byte  (req_tx_byte),
      .req_miso_in  (req_miso_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_sck_out  (rsp_sck_out),
      .rsp_mosi_out (rsp_mosi_out),
      .rsp_rx_valid (rsp_rx_valid),
      .rsp_rx_byte  (rsp_rx_byte),
      .rsp_tx_empty (rsp_tx_empty),
      .rsp_busy_res (rsp_busy_res),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // advance the shadow controller by one master tick, return the pin word
   function automatic smbt_pkg::rsp_word_type spi_tick(
         input logic kind, input logic [smbt_pkg::BYTE_BITS-1:0] data, input logic miso);
      smbt_pkg::rsp_word_type w;
      logic [smbt_pkg::PRESCALE_W:0] limit;
      logic lead;
      logic last_bit;
      w = '0;
      if (kind && !hold_full) begin
         hold_data = data;
         hold_full = 1'b1;
      end
      if (!in_frame) begin
         sck_lvl = cpol;
         if (hold_full) begin
            tx_sr = hold_data;
            hold_full = 1'b0;
            in_frame = 1'b1;
            bit_cnt = '0;
            pre_cnt = '0;
            rx_sr = '0;
         end
      end else begin
         limit = (smbt_pkg::PRESCALE_W'(1) << baud_sel) - 1'b1;
         if ({1'b0, pre_cnt} >= limit) begin
            // edge kind is judged against the current polarity
            lead = (sck_lvl == cpol);
            last_bit = 1'b0;
            pre_cnt = '0;
            sck_lvl = ~sck_lvl;
            if (lead) begin
               if (!cpha) begin
                  rx_sr = {rx_sr[smbt_pkg::FRAME_BITS-2:0], miso};
               end else if (bit_cnt != 0) begin
                  tx_sr = tx_sr << 1;
               end
            end else begin
               if (!cpha) begin
                  tx_sr = tx_sr << 1;
               end else begin
                  rx_sr = {rx_sr[smbt_pkg::FRAME_BITS-2:0], miso};
               end
               last_bit = (bit_cnt >= smbt_pkg::BIT_LAST);
               bit_cnt = bit_cnt + 1'b1;
            end
            if (last_bit) begin
               rx_hold = rx_sr;
               w.rx_valid = 1'b1;
               in_frame = 1'b0;
               bit_cnt = '0;
               sck_lvl = cpol;
            end
         end else begin
            pre_cnt = pre_cnt + 1'b1;
         end
      end
      w.sck_out = sck_lvl;
      w.mosi_out = tx_sr[smbt_pkg::FRAME_BITS-1];
      w.rx_byte = rx_hold;
      w.tx_empty = ~hold_full;
      w.busy_res = in_frame;
      return w;
   endfunction

   function automatic void check_field(input string fname, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, actual %0h", fname, want, got);
         mismatches++;
      end
   endfunction

   // offer one tick word, with a random gap before it, and wait until taken
   task automatic send_tick(input tick_row_type row);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= row.kind;
      req_tx_byte <= row.tx_byte;
      req_miso_in <= row.miso;
      row_typed <= row.typed;
      row_want <= row.want;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      @(negedge clock);
   endtask

   // hold the sender off until every pin word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pin_words_due.size() != 0) @(negedge clock);
   endtask

   // csr_valid is left high so back-to-back writes need no second assignment
   task automatic write_csr(input logic [smbt_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [smbt_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver back-pressure
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // track config writes, predict accepted ticks, check returned words
   always @(posedge clock) begin : pin_monitor
      smbt_pkg::rsp_word_type want;
      if (!reset) begin
         quiet_cycles = quiet_cycles + 1;
         if (csr_valid && csr_ready) begin
            quiet_cycles = 0;
            case (csr_index)
               smbt_pkg::CSR_BAUD:     baud_sel = csr_wdata[smbt_pkg::BAUD_W-1:0];
               smbt_pkg::CSR_POLARITY: cpol = csr_wdata[0];
               smbt_pkg::CSR_PHASE:    cpha = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            want = spi_tick(req_kind, req_tx_byte, req_miso_in);
            if (row_typed) want = row_want;
            pin_words_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (pin_words_due.size() == 0) begin
               $error("result word with nothing expected");
               mismatches++;
            end else begin
               want = pin_words_due.pop_front();
               check_field("sck_out", want.sck_out, rsp_sck_out);
               check_field("mosi_out", want.mosi_out, rsp_mosi_out);
               check_field("rx_valid", want.rx_valid, rsp_rx_valid);
               check_field("rx_byte", want.rx_byte, rsp_rx_byte);
               check_field("tx_empty", want.tx_empty, rsp_tx_empty);
               check_field("busy_res", want.busy_res, rsp_busy_res);
            end
         end
      end
   end

   // end the run if nothing moves for too long
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int n_items;
      logic [smbt_pkg::BAUD_W-1:0] baud;
      tick_row_type row;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words at reset configuration
      foreach (dir_rows[i]) send_tick(dir_rows[i]);

      // random phases, each under its own mode and idling pattern
      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_results();
         case (p)
            5:       baud = 3'd7;
            6:       baud = 3'd0;
            9:       baud = 3'd3;
            default: baud = 3'($urandom_range(2));
         endcase
         write_csr(smbt_pkg::CSR_BAUD, {5'($urandom_range(31)), baud});
         write_csr(smbt_pkg::CSR_POLARITY, {7'($urandom_range(127)), p[1]});
         write_csr(smbt_pkg::CSR_PHASE, {7'($urandom_range(127)), p[2]});
         if (p % 3 == 2) write_csr(CSR_UNUSED, 8'($urandom_range(255)));
         csr_valid <= 1'b0;
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 61; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 61; end
            default: begin gap_pct = 35; stall_pct = 35; end
         endcase
         // the slowest divider only gets a partial frame, finished at a fast rate
         n_items = (p == 5) ? 120 : 165;
         for (int n = 0; n < n_items; n++) begin
            row.kind = ($urandom_range(99) < 30);
            row.tx_byte = 8'($urandom_range(255));
            row.miso = 1'($urandom_range(1));
            row.typed = 1'b0;
            row.want = '0;
            send_tick(row);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/smbt_pkg.sv
src/smbt_in_reg.sv
src/smbt_engine.sv
src/smbt_out_reg.sv
src/spi_master_byte_transceiver_core.sv
dv/tb_spi_master_byte_transceiver_core.sv
